// ===== hw/rtl/u8dec_pkg.sv =====
`default_nettype none

package u8dec_pkg;

	// Field widths of the byte and result words.
	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int CNT_W  = 2;

	// Byte classes found by the front end.
	localparam logic [2:0] TOK_CONT  = 3'd0;
	localparam logic [2:0] TOK_LEAD2 = 3'd1;
	localparam logic [2:0] TOK_LEAD3 = 3'd2;
	localparam logic [2:0] TOK_LEAD4 = 3'd3;
	localparam logic [2:0] TOK_BAD   = 3'd4;

	// Prefix tags of the UTF-8 byte forms.
	localparam logic [1:0] TAG_CONT  = 2'b10;
	localparam logic [2:0] TAG_LEAD2 = 3'b110;
	localparam logic [3:0] TAG_LEAD3 = 4'b1110;
	localparam logic [4:0] TAG_LEAD4 = 5'b11110;

	// Result kinds.
	localparam logic RES_DONE = 1'b0;
	localparam logic RES_ERR  = 1'b1;

	// Queue between front and back ends.
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// One classified byte: its class and its six low bits.
	typedef struct packed {
		logic [2:0] kind;
		logic [5:0] bits;
	} tok_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic valid;
		tok_t tok;
	} head_t;

endpackage

`default_nettype wire

// ===== hw/rtl/u8dec_byte_if.sv =====
`default_nettype none

interface u8dec_byte_if;
	logic                          valid;
	logic                          ready;
	logic [u8dec_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8dec_res_if.sv =====
`default_nettype none

interface u8dec_res_if;
	logic                         valid;
	logic                         ready;
	logic                         result_kind;
	logic [u8dec_pkg::CP_W-1:0]  code_point;
	logic [u8dec_pkg::CNT_W-1:0] byte_count;

	modport source (output valid, output result_kind, output code_point, output byte_count,
		input ready);
	modport sink (input valid, input result_kind, input code_point, input byte_count,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8dec_front.sv =====
`default_nettype none

module u8dec_front (
	u8dec_byte_if.sink      stream,
	input  wire logic       q_full,
	output logic            push,
	output u8dec_pkg::tok_t push_tok
);
	import u8dec_pkg::*;

	logic [BYTE_W-1:0] b;

	assign b = stream.in_byte;

	// A word is taken whenever the queue has room.
	assign stream.ready = !q_full;
	assign push         = stream.valid && !q_full;

	// Classify the byte by its prefix tag.
	always_comb begin
		push_tok.bits = b[5:0];
		if (b[7:6] == TAG_CONT) begin
			push_tok.kind = TOK_CONT;
		end else if (b[7:5] == TAG_LEAD2) begin
			push_tok.kind = TOK_LEAD2;
		end else if (b[7:4] == TAG_LEAD3) begin
			push_tok.kind = TOK_LEAD3;
		end else if (b[7:3] == TAG_LEAD4) begin
			push_tok.kind = TOK_LEAD4;
		end else begin
			push_tok.kind = TOK_BAD;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/u8dec_queue.sv =====
`default_nettype none

module u8dec_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire u8dec_pkg::tok_t        push_tok,
	output logic                        full,
	input  wire logic                   pop,
	output u8dec_pkg::head_t            head
);
	import u8dec_pkg::*;

	tok_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.tok   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/u8dec_back.sv =====
`default_nettype none

module u8dec_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire u8dec_pkg::head_t head,
	output logic                  pop,
	u8dec_res_if.source           result
);
	import u8dec_pkg::*;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_2B_LAST = 3'd1;
	localparam logic [2:0] PH_3B_C1   = 3'd2;
	localparam logic [2:0] PH_3B_C2   = 3'd3;
	localparam logic [2:0] PH_4B_C1   = 3'd4;
	localparam logic [2:0] PH_4B_C2   = 3'd5;
	localparam logic [2:0] PH_4B_C3   = 3'd6;

	logic [2:0]       phase_q;
	logic [CP_W-1:0]  value_q;
	logic             nz_q;
	logic [CNT_W-1:0] kept_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [CP_W-1:0]  out_cp_q;
	logic [CNT_W-1:0] out_cnt_q;

	logic [2:0]       phase_n;
	logic [CP_W-1:0]  value_n;
	logic             nz_n;
	logic [CNT_W-1:0] kept_n;
	logic [CP_W-1:0]  shifted;
	logic             note_en;
	logic [7:0]       note_val;
	logic             do_done;
	logic             do_err;

	// Take a word from the queue when the output register is free or drains.
	assign pop = head.valid && (!out_valid_q || result.ready);

	assign shifted = {value_q[CP_W-7:0], head.tok.bits};

	// Sequence tracking: next phase, partial value and the byte to count.
	always_comb begin
		phase_n  = phase_q;
		value_n  = value_q;
		note_en  = 1'b0;
		note_val = 8'h00;
		do_done  = 1'b0;
		do_err   = 1'b0;
		if (phase_q == PH_IDLE) begin
			case (head.tok.kind)
				TOK_LEAD2: begin
					value_n  = {16'h0000, head.tok.bits[4:0]};
					note_en  = 1'b1;
					note_val = {5'h00, head.tok.bits[4:2]};
					phase_n  = PH_2B_LAST;
				end
				TOK_LEAD3: begin
					value_n = {17'h00000, head.tok.bits[3:0]};
					phase_n = PH_3B_C1;
				end
				TOK_LEAD4: begin
					value_n = {18'h00000, head.tok.bits[2:0]};
					phase_n = PH_4B_C1;
				end
				default: begin
					do_err = 1'b1;
				end
			endcase
		end else if (head.tok.kind != TOK_CONT) begin
			do_err = 1'b1;
		end else begin
			value_n = shifted;
			unique case (phase_q)
				PH_2B_LAST, PH_3B_C2, PH_4B_C3: begin
					note_en  = 1'b1;
					note_val = shifted[7:0];
					do_done  = 1'b1;
				end
				PH_3B_C1: begin
					note_en  = 1'b1;
					note_val = shifted[9:2];
					phase_n  = PH_3B_C2;
				end
				PH_4B_C1: begin
					note_en  = 1'b1;
					note_val = {3'b000, shifted[8:4]};
					phase_n  = PH_4B_C2;
				end
				PH_4B_C2: begin
					note_en  = 1'b1;
					note_val = shifted[9:2];
					phase_n  = PH_4B_C3;
				end
				default: begin
					do_err = 1'b1;
				end
			endcase
		end
	end

	// A code point byte is counted once it is nonzero or a higher one was counted.
	always_comb begin
		nz_n   = nz_q;
		kept_n = kept_q;
		if (note_en && (nz_q || (note_val != 8'h00))) begin
			nz_n   = 1'b1;
			kept_n = kept_q + 1'b1;
		end
	end

	// Sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			value_q <= '0;
			nz_q    <= 1'b0;
			kept_q  <= '0;
		end else if (pop) begin
			if (do_done || do_err) begin
				phase_q <= PH_IDLE;
				value_q <= '0;
				nz_q    <= 1'b0;
				kept_q  <= '0;
			end else begin
				phase_q <= phase_n;
				value_q <= value_n;
				nz_q    <= nz_n;
				kept_q  <= kept_n;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && (do_done || do_err)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop && (do_done || do_err)) begin
			if (do_err) begin
				out_kind_q <= RES_ERR;
				out_cp_q   <= '0;
				out_cnt_q  <= '0;
			end else begin
				out_kind_q <= RES_DONE;
				out_cp_q   <= value_n;
				out_cnt_q  <= kept_n;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.code_point  = out_cp_q;
	assign result.byte_count  = out_cnt_q;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_multibyte_decoder.sv =====
`default_nettype none

// Channel  Dir  Words                                       Accepted when
// stream   in   in_byte[7:0]                                valid && ready
// result   out  result_kind, code_point[20:0], byte_count   valid && ready
//
// One byte is taken per cycle while the queue has room; the byte that completes
// or breaks a sequence reaches the result through the queue and output register.
// Rate is set by the back end: one queued byte per cycle unless the result stalls.
// Reset clears the queue, the sequence state and the output register.
// A stalled result holds the back end; the four-entry queue keeps taking bytes
// until it fills.

module utf8_multibyte_decoder (
	input  wire logic   clk,
	input  wire logic   arst_n,
	u8dec_byte_if.sink  stream,
	u8dec_res_if.source result
);
	import u8dec_pkg::*;

	logic  push;
	tok_t  push_tok;
	logic  q_full;
	logic  pop;
	head_t head;

	// Byte classifier.
	u8dec_front u_front (
		.stream   (stream),
		.q_full   (q_full),
		.push     (push),
		.push_tok (push_tok)
	);

	// Queue of classified bytes.
	u8dec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	// Sequence decoder and output register.
	u8dec_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import u8dec_pkg::*;

	localparam int CYCLE_LIMIT  = 50000;
	localparam int RANDOM_BYTES = 1600;
	localparam int IDLE_PCT     = 17;
	localparam int CALM_FIRST   = 700;
	localparam int CALM_LAST    = 1000;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 8;

	// Position inside a multibyte sequence.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_2B_LAST,
		PH_3B_C1,
		PH_3B_C2,
		PH_4B_C1,
		PH_4B_C2,
		PH_4B_C3
	} seq_phase_e;

	// One decoded result word.
	typedef struct {
		logic            kind;
		logic [CP_W-1:0] cp;
		logic [CNT_W-1:0] cnt;
	} cp_word_t;

	logic clk;
	logic arst_n;

	u8dec_byte_if stream_if ();
	u8dec_res_if  result_if ();

	utf8_multibyte_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	logic [BYTE_W-1:0] byte_q[$];
	cp_word_t          decoded_q[$];
	int                bytes_accepted;
	int                err_count;
	int                cycle_count;
	logic              hold_rx;
	logic              calm;

	// Decoder state mirrored by the predictor.
	seq_phase_e        ph;
	logic [CP_W-1:0]   acc;
	logic              seen;
	logic [CNT_W-1:0]  kept;

	assign calm = (bytes_accepted >= CALM_FIRST) && (bytes_accepted < CALM_LAST);

	function automatic void clear_seq();
		ph   = PH_IDLE;
		acc  = '0;
		seen = 1'b0;
		kept = '0;
	endfunction

	// A byte of the code point counts once it is nonzero or a higher byte counted.
	function automatic void note_sig(input logic [7:0] v);
		if (seen || v != 8'd0) begin
			kept = kept + 1'b1;
			seen = 1'b1;
		end
	endfunction

	function automatic void flag_error();
		cp_word_t w;
		w.kind = RES_ERR;
		w.cp   = '0;
		w.cnt  = '0;
		clear_seq();
		decoded_q.push_back(w);
	endfunction

	// Advance the mirrored decoder by one byte and queue any result it gives.
	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		cp_word_t w;
		if (ph == PH_IDLE) begin
			if (b[7:5] == TAG_LEAD2) begin
				acc = CP_W'(b[4:0]);
				note_sig(8'(b[4:2]));
				ph = PH_2B_LAST;
			end else if (b[7:4] == TAG_LEAD3) begin
				acc = CP_W'(b[3:0]);
				ph = PH_3B_C1;
			end else if (b[7:3] == TAG_LEAD4) begin
				acc = CP_W'(b[2:0]);
				ph = PH_4B_C1;
			end else begin
				flag_error();
			end
			return;
		end
		if (b[7:6] != TAG_CONT) begin
			flag_error();
			return;
		end
		acc = {acc[CP_W-7:0], b[5:0]};
		case (ph)
			PH_2B_LAST, PH_3B_C2, PH_4B_C3: begin
				note_sig(acc[7:0]);
				w.kind = RES_DONE;
				w.cp   = acc;
				w.cnt  = kept;
				clear_seq();
				decoded_q.push_back(w);
			end
			PH_3B_C1: begin
				note_sig(acc[9:2]);
				ph = PH_3B_C2;
			end
			PH_4B_C1: begin
				note_sig(acc[11:4]);
				ph = PH_4B_C2;
			end
			PH_4B_C2: begin
				note_sig(acc[9:2]);
				ph = PH_4B_C3;
			end
			default: begin
				flag_error();
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
			cycle_count, what, got, want);
		err_count++;
	endtask

	// Lead byte of a sequence of the given length, payload random or zero.
	function automatic logic [7:0] lead_byte(input int len, input bit sparse);
		logic [7:0] b;
		case (len)
			2: b = {TAG_LEAD2, sparse ? 5'd0 : 5'($urandom)};
			3: b = {TAG_LEAD3, sparse ? 4'd0 : 4'($urandom)};
			default: b = {TAG_LEAD4, sparse ? 3'd0 : 3'($urandom)};
		endcase
		return b;
	endfunction

	function automatic logic [7:0] cont_byte(input bit sparse);
		return {TAG_CONT, (sparse && $urandom_range(1) == 0) ? 6'd0 : 6'($urandom)};
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("utf8_multibyte_decoder verification failed");
			$finish;
		end
	end

	// Byte driver: offers queued words with random gaps, holding each until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_if.valid   <= 1'b0;
			stream_if.in_byte <= '0;
		end else begin
			if (stream_if.valid && stream_if.ready) begin
				decode_byte(stream_if.in_byte);
				bytes_accepted++;
			end
			if (!stream_if.valid || stream_if.ready) begin
				if (byte_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					stream_if.valid   <= 1'b1;
					stream_if.in_byte <= byte_q.pop_front();
				end else begin
					stream_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted word and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		cp_word_t w;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch("unexpected result kind", result_if.result_kind, 0);
				end else begin
					w = decoded_q.pop_front();
					if (result_if.result_kind !== w.kind)
						report_mismatch("result_kind", result_if.result_kind, w.kind);
					if (result_if.code_point !== w.cp)
						report_mismatch("code_point", result_if.code_point, w.cp);
					if (result_if.byte_count !== w.cnt)
						report_mismatch("byte_count", result_if.byte_count, w.cnt);
				end
			end
			result_if.ready <= !hold_rx && (calm || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// Long receiver hold-off so the input queue fills and the stream stalls.
	initial begin
		hold_rx = 1'b0;
		@(posedge arst_n);
		while (bytes_accepted < HOLD_AT)
			@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// Stimulus, reset and end of run.
	initial begin
		int         r;
		int         len;
		int         cut;
		bit         sparse;
		logic [7:0] b;

		arst_n            = 1'b0;
		stream_if.valid   = 1'b0;
		stream_if.in_byte = '0;
		result_if.ready   = 1'b0;
		bytes_accepted    = 0;
		err_count         = 0;
		cycle_count       = 0;
		clear_seq();

		// Directed: ASCII, stray continuations, illegal leads, the largest of each
		// length, zero code points, and sequences broken by a missing continuation.
		byte_q = {8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
			8'hC0, 8'h80, 8'hDF, 8'hBF,
			8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
			8'hF7, 8'hBF, 8'hBF, 8'hBF,
			8'hC2, 8'h41, 8'hF0, 8'h90, 8'hE5};

		// Random: mostly well-formed sequences, some broken ones and raw noise.
		while (byte_q.size() < RANDOM_BYTES + 25) begin
			r      = $urandom_range(99);
			len    = $urandom_range(2, 4);
			sparse = ($urandom_range(3) == 0);
			if (r < 70) begin
				byte_q.push_back(lead_byte(len, sparse));
				for (int i = 1; i < len; i++)
					byte_q.push_back(cont_byte(sparse));
			end else if (r < 85) begin
				cut = $urandom_range(len - 1);
				byte_q.push_back(lead_byte(len, sparse));
				for (int i = 0; i < cut; i++)
					byte_q.push_back(cont_byte(sparse));
				do
					b = 8'($urandom);
				while (b[7:6] == TAG_CONT);
				byte_q.push_back(b);
			end else begin
				byte_q.push_back(8'($urandom));
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_q.size() != 0 || stream_if.valid)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0) begin
			$display("utf8_multibyte_decoder verification clean");
		end else begin
			$display("utf8_multibyte_decoder verification failed");
		end
		$finish;
	end

endmodule
